// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the timer table.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer table check failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer table check failed: next-cycle rule");

`endif

// ----- rtl/core/ptt_pkg.sv -----
// Shared types and constants for the periodic task timer table.
// Used by the controller, the datapath, the divider and the checker.
package ptt_pkg;

	localparam int DIVIDEND_W  = 20;
	localparam int TICK_W      = 10;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 3;
	localparam int MODE_W      = 2;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [TICK_W-1:0] TICK_LEN_RESET = 10'd10;

	localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEL      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd3;

	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DUE       = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic idx_inc;
		logic walk_read;
		logic div_start;
		logic add_write;
		logic emit_full;
		logic del_do;
		logic walk_finish;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic idx_last;
		logic free_hit;
		logic div_done;
	} dp_status_t;

endpackage

// ----- rtl/core/ptt_div.sv -----
// Two-lane restoring divider: one quotient bit per lane per cycle, shared divisor.
// Depends on ptt_pkg for the dividend and divisor widths.
module ptt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ptt_pkg::TICK_W-1:0]      divisor,
	input  logic [ptt_pkg::DIVIDEND_W-1:0]  dvd_a,
	input  logic [ptt_pkg::DIVIDEND_W-1:0]  dvd_b,
	output logic                            done,
	output logic [ptt_pkg::DIVIDEND_W-1:0]  quot_a,
	output logic [ptt_pkg::DIVIDEND_W-1:0]  quot_b
);
	import ptt_pkg::*;

	localparam int STEP_W = $clog2(DIVIDEND_W);

	logic                  run_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [TICK_W-1:0]     dvsr_q;
	logic [TICK_W-1:0]     rem_a_q;
	logic [TICK_W-1:0]     rem_b_q;
	logic [DIVIDEND_W-1:0] dq_a_q;
	logic [DIVIDEND_W-1:0] dq_b_q;
	logic [TICK_W:0]       nxt_a;
	logic [TICK_W:0]       nxt_b;

	// Returns {quotient bit, new remainder} for one restoring step.
	function automatic logic [TICK_W:0] div_step(input logic [TICK_W-1:0] rem,
			input logic nb, input logic [TICK_W-1:0] d);
		logic [TICK_W:0]   sh;
		logic [TICK_W+1:0] diff;
		sh   = {rem, nb};
		diff = {1'b0, sh} - {2'b00, d};
		if (diff[TICK_W+1]) begin
			div_step = {1'b0, sh[TICK_W-1:0]};
		end else begin
			div_step = {1'b1, diff[TICK_W-1:0]};
		end
	endfunction

	assign nxt_a = div_step(rem_a_q, dq_a_q[DIVIDEND_W-1], dvsr_q);
	assign nxt_b = div_step(rem_b_q, dq_b_q[DIVIDEND_W-1], dvsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register shifts out its top bit and takes in the quotient bit.
	always_ff @(posedge clk) begin
		if (start) begin
			dvsr_q  <= divisor;
			rem_a_q <= '0;
			rem_b_q <= '0;
			dq_a_q  <= dvd_a;
			dq_b_q  <= dvd_b;
		end else if (run_q) begin
			rem_a_q <= nxt_a[TICK_W-1:0];
			rem_b_q <= nxt_b[TICK_W-1:0];
			dq_a_q  <= {dq_a_q[DIVIDEND_W-2:0], nxt_a[TICK_W]};
			dq_b_q  <= {dq_b_q[DIVIDEND_W-2:0], nxt_b[TICK_W]};
		end
	end

	assign done   = done_q;
	assign quot_a = dq_a_q;
	assign quot_b = dq_b_q;

endmodule

// ----- rtl/core/ptt_ctrl.sv -----
// Controller state machine of the timer table: sequences add, delete and slot walks.
// Depends on ptt_pkg for the command and status structs and the mode codes.
module ptt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ptt_pkg::MODE_W-1:0]  mode,
	output logic                        busy,
	output ptt_pkg::cmd_t               cmd,
	input  ptt_pkg::dp_status_t         dp_st
);
	import ptt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_DEL    = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_DRAIN  = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (mode) inside
						MODE_ADD:                state_d = S_SCAN;
						MODE_DEL:                state_d = S_DEL;
						MODE_TICK, MODE_DISPATCH: state_d = S_WALK;
						default:                 state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (dp_st.free_hit) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else if (dp_st.idx_last) begin
					cmd.emit_full = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_DIV: begin
				if (dp_st.div_done) begin
					cmd.add_write = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DEL: begin
				cmd.del_do = 1'b1;
				state_d    = S_IDLE;
			end
			S_WALK: begin
				cmd.walk_read = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (dp_st.idx_last) begin
					state_d = S_DRAIN;
				end
			end
			// The last slot read is still being processed here.
			S_DRAIN: state_d = S_FINISH;
			S_FINISH: begin
				cmd.walk_finish = 1'b1;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/core/ptt_dpath.sv -----
// Datapath of the timer table: slot marks, countdown and period memories, walk stage,
// tick-length register and result registers. Depends on ptt_pkg and ptt_div.
module ptt_dpath #(
	parameter int TASK_SLOTS = 16,
	parameter int TIME_BITS  = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ptt_pkg::TICK_W-1:0]      cfg_wdata,
	input  logic [ptt_pkg::MODE_W-1:0]      mode,
	input  logic [ptt_pkg::DIVIDEND_W-1:0]  delay_time,
	input  logic [ptt_pkg::DIVIDEND_W-1:0]  period_time,
	input  logic [ptt_pkg::SLOT_W-1:0]      slot,
	input  ptt_pkg::cmd_t                   cmd,
	output ptt_pkg::dp_status_t             dp_st,
	output logic                            result_valid,
	output logic [ptt_pkg::STATUS_W-1:0]    status,
	output logic [ptt_pkg::SLOT_W-1:0]      task_slot,
	output logic                            last
);
	import ptt_pkg::*;

	localparam int IDX_W = $clog2(TASK_SLOTS);

	logic [TICK_W-1:0]     tick_len_q;
	logic [MODE_W-1:0]     mode_q;
	logic [DIVIDEND_W-1:0] delay_q;
	logic [DIVIDEND_W-1:0] period_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [IDX_W-1:0]      idx_q;
	logic                  idx_last;
	logic [IDX_W-1:0]      idx_s1;
	logic                  valid_s1;
	logic [TIME_BITS-1:0]  cd_rd_s1;
	logic [TIME_BITS-1:0]  per_rd_s1;

	logic [TASK_SLOTS-1:0] active_q;
	logic [TASK_SLOTS-1:0] ready_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  pend_valid_q;
	logic [IDX_W-1:0]      pend_slot_q;

	logic [TIME_BITS-1:0]  cd_mem  [TASK_SLOTS];
	logic [TIME_BITS-1:0]  per_mem [TASK_SLOTS];

	logic                  div_done;
	logic [TICK_W-1:0]     divisor;
	logic [DIVIDEND_W-1:0] q_delay;
	logic [DIVIDEND_W-1:0] q_period;
	logic [TIME_BITS-1:0]  cd_ticks;
	logic [TIME_BITS-1:0]  per_ticks;

	logic                  tick_s1;
	logic                  tick_wr;
	logic                  disp_find;
	logic                  del_in_range;
	logic [IDX_W-1:0]      sel_idx;
	logic                  del_hit;
	logic                  cd_we;
	logic [IDX_W-1:0]      cd_waddr;
	logic [TIME_BITS-1:0]  cd_wdata;

	logic                  emit_v;
	logic [STATUS_W-1:0]   emit_status;
	logic [SLOT_W-1:0]     emit_slot;
	logic                  emit_last;

	logic                  result_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [SLOT_W-1:0]     task_slot_q;
	logic                  last_q;

	// Tick length register; zero divides as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len_q <= TICK_LEN_RESET;
		end else if (cfg_we) begin
			tick_len_q <= cfg_wdata;
		end
	end

	assign divisor = (tick_len_q == '0) ? TICK_W'(1) : tick_len_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			delay_q  <= delay_time;
			period_q <= period_time;
			slot_q   <= slot;
		end
	end

	ptt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (divisor),
		.dvd_a   (delay_q),
		.dvd_b   (period_q),
		.done    (div_done),
		.quot_a  (q_delay),
		.quot_b  (q_period)
	);

	// Quotients larger than the countdown width saturate.
	if (TIME_BITS >= DIVIDEND_W) begin : g_wide
		assign cd_ticks  = TIME_BITS'(q_delay);
		assign per_ticks = TIME_BITS'(q_period);
	end else begin : g_sat
		assign cd_ticks  = ((q_delay >> TIME_BITS) != '0) ? '1 : TIME_BITS'(q_delay);
		assign per_ticks = ((q_period >> TIME_BITS) != '0) ? '1 : TIME_BITS'(q_period);
	end

	// Slot index shared by the free-slot scan and the walk.
	assign idx_last = (idx_q == IDX_W'(TASK_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_read;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	assign tick_s1   = valid_s1 && (mode_q == MODE_TICK);
	assign tick_wr   = tick_s1 && active_q[idx_s1];
	assign disp_find = valid_s1 && (mode_q == MODE_DISPATCH) && active_q[idx_s1]
		&& ready_q[idx_s1] && (cnt_q != CNT_W'(MAX_RESULTS));

	assign del_in_range = (int'(slot_q) < TASK_SLOTS);
	assign sel_idx      = IDX_W'(slot_q);
	assign del_hit      = del_in_range && active_q[sel_idx];

	// A slot at zero reloads from its period; a one-shot slot stays at zero.
	assign cd_we    = cmd.add_write || tick_wr;
	assign cd_waddr = cmd.add_write ? idx_q : idx_s1;
	always_comb begin
		if (cmd.add_write) begin
			cd_wdata = cd_ticks;
		end else if (cd_rd_s1 == '0) begin
			cd_wdata = per_rd_s1;
		end else begin
			cd_wdata = cd_rd_s1 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cd_we) begin
			cd_mem[cd_waddr] <= cd_wdata;
		end
		if (cmd.add_write) begin
			per_mem[idx_q] <= per_ticks;
		end
		cd_rd_s1  <= cd_mem[idx_q];
		per_rd_s1 <= per_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			ready_q  <= '0;
		end else begin
			if (cmd.add_write) begin
				active_q[idx_q] <= 1'b1;
				ready_q[idx_q]  <= 1'b0;
			end
			if (cmd.del_do && del_hit) begin
				active_q[sel_idx] <= 1'b0;
				ready_q[sel_idx]  <= 1'b0;
			end
			if (tick_wr && (cd_rd_s1 == '0)) begin
				ready_q[idx_s1] <= 1'b1;
			end
			if (disp_find) begin
				ready_q[idx_s1] <= 1'b0;
				if (per_rd_s1 == '0) begin
					active_q[idx_s1] <= 1'b0;
				end
			end
		end
	end

	// A due slot is held back one find so that the final one can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (disp_find) begin
			cnt_q        <= cnt_q + 1'b1;
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (disp_find) begin
			pend_slot_q <= idx_s1;
		end
	end

	always_comb begin
		emit_v      = 1'b0;
		emit_status = ST_ADDED;
		emit_slot   = '0;
		emit_last   = 1'b1;
		if (cmd.emit_full) begin
			emit_v      = 1'b1;
			emit_status = ST_FULL;
		end else if (cmd.add_write) begin
			emit_v      = 1'b1;
			emit_status = ST_ADDED;
			emit_slot   = SLOT_W'(idx_q);
		end else if (cmd.del_do) begin
			emit_v      = 1'b1;
			emit_status = del_hit ? ST_DELETED : ST_IGNORED;
			emit_slot   = slot_q;
		end else if (disp_find && pend_valid_q) begin
			emit_v      = 1'b1;
			emit_status = ST_DUE;
			emit_slot   = SLOT_W'(pend_slot_q);
			emit_last   = 1'b0;
		end else if (cmd.walk_finish) begin
			emit_v = 1'b1;
			if (mode_q == MODE_TICK) begin
				emit_status = ST_TICK_DONE;
			end else if (pend_valid_q) begin
				emit_status = ST_DUE;
				emit_slot   = SLOT_W'(pend_slot_q);
			end else begin
				emit_status = ST_NONE_DUE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit_v;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v) begin
			status_q    <= emit_status;
			task_slot_q <= emit_slot;
			last_q      <= emit_last;
		end
	end

	assign dp_st.idx_last = idx_last;
	assign dp_st.free_hit = !active_q[idx_q];
	assign dp_st.div_done = div_done;

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign task_slot    = task_slot_q;
	assign last         = last_q;

endmodule

// ----- rtl/core/periodic_task_timer_table.sv -----
// Top level of the periodic task timer table: controller plus datapath.
// Depends on ptt_pkg, ptt_ctrl, ptt_dpath and ptt_div.
//
//   Channel   Handshake                  Payload
//   command   start, busy (start & !busy) mode, delay_time, period_time, slot
//   result    result_valid strobe         status, task_slot, last
//   config    cfg_we                      cfg_wdata (tick length)
//
// Delete acts in a single state after acceptance. Tick and dispatch walk one slot
// per cycle through the countdown and period memories. Add scans the active marks
// for the first free slot, runs the bit-serial divider and writes the slot once the
// divider signals done; a full table ends the scan at the last slot with a full result.
// Each result shows in the cycle after it is produced and the receiver cannot stall it.
// Reset clears all slots; no clearing pass follows.
module periodic_task_timer_table #(
	parameter int TASK_SLOTS = 16,
	parameter int TIME_BITS  = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ptt_pkg::TICK_W-1:0]      cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  logic [ptt_pkg::MODE_W-1:0]      mode,
	input  logic [ptt_pkg::DIVIDEND_W-1:0]  delay_time,
	input  logic [ptt_pkg::DIVIDEND_W-1:0]  period_time,
	input  logic [ptt_pkg::SLOT_W-1:0]      slot,
	output logic                            result_valid,
	output logic [ptt_pkg::STATUS_W-1:0]    status,
	output logic [ptt_pkg::SLOT_W-1:0]      task_slot,
	output logic                            last
);
	import ptt_pkg::*;

	cmd_t       cmd;
	dp_status_t dp_st;

	ptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.cmd    (cmd),
		.dp_st  (dp_st)
	);

	ptt_dpath #(
		.TASK_SLOTS (TASK_SLOTS),
		.TIME_BITS  (TIME_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mode         (mode),
		.delay_time   (delay_time),
		.period_time  (period_time),
		.slot         (slot),
		.cmd          (cmd),
		.dp_st        (dp_st),
		.result_valid (result_valid),
		.status       (status),
		.task_slot    (task_slot),
		.last         (last)
	);

endmodule

// ----- rtl/core/ptt_checker.sv -----
// Port-level checks on the timer table's command and result behavior over time.
// Depends on ptt_pkg and assert_macros.svh; bound to periodic_task_timer_table.
`include "assert_macros.svh"

module ptt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          result_valid,
	input logic [ptt_pkg::STATUS_W-1:0]  status,
	input logic                          last
);
	import ptt_pkg::*;

	// An accepted command always makes the block busy in the next cycle.
	`PTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// The final result of a command is never followed by a result in the next cycle.
	`PTT_ASSERT_NEXT(a_last_gap, result_valid && last, !result_valid)
	// Only dispatch produces more than one result per command.
	`PTT_ASSERT_NOW(a_more_is_due, result_valid && !last, status == ST_DUE)
	// A result that is not the last one arrives while the walk is still running.
	`PTT_ASSERT_NOW(a_more_busy, result_valid && !last, busy)

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.last         (last)
);

// ----- bench/ptt_checker.sv -----
// Scoreboard for the periodic task timer table: watches commands, tick-length writes and
// result strobes, keeps its own copy of the task table and compares every result in order.
// Depends on ptt_pkg for field widths, mode codes and status codes.
`timescale 1ns / 1ps

module ptt_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptt_pkg::TICK_W-1:0]     cfg_wdata,
	input  logic                           start,
	input  logic                           busy,
	input  logic [ptt_pkg::MODE_W-1:0]     mode,
	input  logic [ptt_pkg::DIVIDEND_W-1:0] delay_time,
	input  logic [ptt_pkg::DIVIDEND_W-1:0] period_time,
	input  logic [ptt_pkg::SLOT_W-1:0]     slot,
	input  logic                           result_valid,
	input  logic [ptt_pkg::STATUS_W-1:0]   status,
	input  logic [ptt_pkg::SLOT_W-1:0]     task_slot,
	input  logic                           last,
	output int                             fail_count,
	output int                             outstanding,
	output int                             results_seen
);
	import ptt_pkg::*;

	localparam int SLOTS = 16;
	localparam int TBITS = 20;
	localparam longint unsigned TICKS_CAP = (64'd1 << TBITS) - 1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} report_t;

	report_t           pending_reports[$];
	logic [TICK_W-1:0] tick_len;
	logic              slot_used   [SLOTS];
	logic              slot_ready  [SLOTS];
	logic [TBITS-1:0]  remaining   [SLOTS];
	logic [TBITS-1:0]  reload      [SLOTS];

	function automatic void flag(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] timer table mismatch: %s", $time, what);
	endfunction

	function automatic void queue_report(input logic [STATUS_W-1:0] st,
			input logic [SLOT_W-1:0] sl, input logic lst);
		report_t r;
		r.status = st;
		r.slot   = sl;
		r.last   = lst;
		pending_reports.push_back(r);
	endfunction

	function automatic void release_slot(input int k);
		slot_used[k]  = 1'b0;
		slot_ready[k] = 1'b0;
		remaining[k]  = '0;
		reload[k]     = '0;
	endfunction

	// A tick length of zero divides as one; quotients wider than the counters saturate.
	function automatic logic [TBITS-1:0] ticks_of(input logic [DIVIDEND_W-1:0] t);
		longint unsigned q;
		q = t / ((tick_len == '0) ? 10'd1 : tick_len);
		if (q > TICKS_CAP)
			q = TICKS_CAP;
		return q[TBITS-1:0];
	endfunction

	function automatic void apply_command(input logic [MODE_W-1:0] op,
			input logic [DIVIDEND_W-1:0] dly, input logic [DIVIDEND_W-1:0] per,
			input logic [SLOT_W-1:0] sel);
		int k;
		int total;
		int n;
		total = 0;
		n = 0;
		case (op)
			MODE_ADD: begin
				k = 0;
				while (k < SLOTS && slot_used[k])
					k++;
				if (k == SLOTS) begin
					queue_report(ST_FULL, '0, 1'b1);
				end else begin
					slot_used[k]  = 1'b1;
					slot_ready[k] = 1'b0;
					remaining[k]  = ticks_of(dly);
					reload[k]     = ticks_of(per);
					queue_report(ST_ADDED, SLOT_W'(k), 1'b1);
				end
			end
			MODE_DEL: begin
				if (int'(sel) < SLOTS && slot_used[sel]) begin
					release_slot(int'(sel));
					queue_report(ST_DELETED, sel, 1'b1);
				end else begin
					queue_report(ST_IGNORED, sel, 1'b1);
				end
			end
			MODE_TICK: begin
				for (k = 0; k < SLOTS; k++) begin
					if (slot_used[k]) begin
						if (remaining[k] == '0) begin
							slot_ready[k] = 1'b1;
							if (reload[k] != '0)
								remaining[k] = reload[k];
						end else begin
							remaining[k] = remaining[k] - 1'b1;
						end
					end
				end
				queue_report(ST_TICK_DONE, '0, 1'b1);
			end
			MODE_DISPATCH: begin
				for (k = 0; k < SLOTS; k++)
					if (slot_used[k] && slot_ready[k])
						total++;
				if (total > MAX_RESULTS)
					total = MAX_RESULTS;
				if (total == 0)
					queue_report(ST_NONE_DUE, '0, 1'b1);
				for (k = 0; k < SLOTS && n < total; k++) begin
					if (slot_used[k] && slot_ready[k]) begin
						queue_report(ST_DUE, SLOT_W'(k), n == total - 1);
						n++;
						slot_ready[k] = 1'b0;
						if (reload[k] == '0)
							release_slot(k);
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			tick_len = TICK_LEN_RESET;
			for (int k = 0; k < SLOTS; k++)
				release_slot(k);
			pending_reports.delete();
			fail_count   = 0;
			results_seen = 0;
			outstanding  = 0;
		end else begin
			if (result_valid) begin
				results_seen++;
				if (pending_reports.size() == 0) begin
					flag($sformatf("unexpected result status=%0d task_slot=%0d last=%0b",
						status, task_slot, last));
				end else begin
					want = pending_reports.pop_front();
					if (status !== want.status || task_slot !== want.slot || last !== want.last)
						flag($sformatf("expected status=%0d task_slot=%0d last=%0b, got %0d %0d %0b",
							want.status, want.slot, want.last, status, task_slot, last));
				end
			end
			if (cfg_we)
				tick_len = cfg_wdata;
			if (start && !busy)
				apply_command(mode, delay_time, period_time, slot);
			outstanding = pending_reports.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Top of the timer table testbench: clock, reset, command and tick-length stimulus, verdict.
// Depends on ptt_pkg, the periodic_task_timer_table RTL and the ptt_scoreboard checker.
`timescale 1ns / 1ps

module tb_top;
	import ptt_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [TICK_W-1:0]     cfg_wdata;
	logic                  start;
	logic                  busy;
	logic [MODE_W-1:0]     mode;
	logic [DIVIDEND_W-1:0] delay_time;
	logic [DIVIDEND_W-1:0] period_time;
	logic [SLOT_W-1:0]     slot;
	logic                  result_valid;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_W-1:0]     task_slot;
	logic                  last;

	int fail_count;
	int outstanding;
	int results_seen;
	int n_cmd [4];
	int tl_now;
	bit calm;

	// Per phase: tick length, command count and the add/delete/tick percentages.
	int tl_plan   [6] = '{1, 1000, 0, 1023, 7, 3};
	int len_plan  [6] = '{55, 55, 50, 50, 50, 50};
	int add_plan  [6] = '{30, 30, 70, 30, 25, 35};
	int del_plan  [6] = '{15, 15, 5, 15, 35, 10};
	int tick_plan [6] = '{35, 35, 15, 35, 25, 35};

	periodic_task_timer_table DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .mode(mode), .delay_time(delay_time),
		.period_time(period_time), .slot(slot), .result_valid(result_valid),
		.status(status), .task_slot(task_slot), .last(last)
	);

	ptt_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .mode(mode), .delay_time(delay_time),
		.period_time(period_time), .slot(slot), .result_valid(result_valid),
		.status(status), .task_slot(task_slot), .last(last),
		.fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Entered and left at a falling edge; start stays high into the next command.
	task automatic issue(input logic [MODE_W-1:0] op, input logic [DIVIDEND_W-1:0] dly,
			input logic [DIVIDEND_W-1:0] per, input logic [SLOT_W-1:0] sel);
		while (!calm && $urandom_range(99) < 16) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		mode        <= op;
		delay_time  <= dly;
		period_time <= per;
		slot        <= sel;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		n_cmd[int'(op)]++;
	endtask

	// The table is only reconfigured once every outstanding result has arrived.
	task automatic set_tick_length(input int value);
		start <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= TICK_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		tl_now = value;
	endtask

	// Delays and periods are mostly a few ticks so tasks fall due often.
	task automatic random_command(input int add_pct, input int del_pct, input int tick_pct);
		int eff;
		int r;
		logic [MODE_W-1:0] op;
		logic [DIVIDEND_W-1:0] dly;
		logic [DIVIDEND_W-1:0] per;
		eff = (tl_now == 0) ? 1 : tl_now;
		r = $urandom_range(99);
		if (r < add_pct)
			op = MODE_ADD;
		else if (r < add_pct + del_pct)
			op = MODE_DEL;
		else if (r < add_pct + del_pct + tick_pct)
			op = MODE_TICK;
		else
			op = MODE_DISPATCH;
		case ($urandom_range(9))
			0: dly = DIVIDEND_W'($urandom);
			1: dly = '1;
			default: dly = DIVIDEND_W'($urandom_range(7 * eff - 1));
		endcase
		case ($urandom_range(5))
			0: per = DIVIDEND_W'($urandom);
			1, 2: per = DIVIDEND_W'($urandom_range(eff - 1));
			default: per = DIVIDEND_W'($urandom_range(6 * eff - 1, eff));
		endcase
		issue(op, dly, per, SLOT_W'($urandom_range(15)));
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = TICK_LEN_RESET;
		start       = 1'b0;
		mode        = MODE_ADD;
		delay_time  = '0;
		period_time = '0;
		slot        = '0;
		tl_now      = 10;
		calm        = 1'b0;
		for (int m = 0; m < 4; m++)
			n_cmd[m] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, then a small mix of one-shot and periodic tasks at the reset tick length.
		issue(MODE_DISPATCH, '0, '0, '0);
		issue(MODE_TICK, '0, '0, '0);
		issue(MODE_DEL, '0, '0, 4'd0);
		issue(MODE_DEL, '0, '0, 4'd15);
		issue(MODE_ADD, '0, '0, '0);
		issue(MODE_ADD, '1, '1, '0);
		issue(MODE_ADD, 20'd25, 20'd30, '0);
		issue(MODE_ADD, 20'd9, 20'd19, '0);
		issue(MODE_ADD, 20'd5, 20'd9, '0);
		issue(MODE_TICK, '0, '0, '0);
		// Undispatched one-shots get marked ready again by this tick.
		issue(MODE_TICK, '0, '0, '0);
		issue(MODE_DISPATCH, '0, '0, '0);
		issue(MODE_DISPATCH, '0, '0, '0);
		issue(MODE_DEL, '0, '0, 4'd1);
		issue(MODE_DEL, '0, '0, 4'd1);
		issue(MODE_ADD, 20'd20, 20'd10, '0);
		issue(MODE_TICK, '0, '0, '0);
		issue(MODE_TICK, '0, '0, '0);
		issue(MODE_TICK, '0, '0, '0);
		issue(MODE_DISPATCH, '0, '0, '0);
		issue(MODE_DEL, '0, '0, 4'd2);
		issue(MODE_DEL, '0, '0, 4'd3);
		issue(MODE_ADD, 20'hA5A5A, 20'h5A5A5, '0);
		issue(MODE_TICK, '0, '0, '0);
		issue(MODE_DISPATCH, '0, '0, '0);

		for (int p = 0; p < 6; p++) begin
			set_tick_length(tl_plan[p]);
			calm = (p == 1);
			repeat (len_plan[p])
				random_command(add_plan[p], del_plan[p], tick_plan[p]);
		end

		start <= 1'b0;
		wait (outstanding == 0);
		repeat (40) @(posedge clk);
		$display("Run covered %0d adds, %0d deletes, %0d ticks and %0d dispatches",
			n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3]);
		$display("over seven tick-length settings; %0d results checked, %0d failures.",
			results_seen, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
